/* rtl/round_robin_run_queue_macros.svh */
// ----------------------------------------------------------------------------
// Run queue assertion macros
// Shared assertion forms for the run queue; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_RUN_QUEUE_MACROS_SVH
`define ROUND_ROBIN_RUN_QUEUE_MACROS_SVH

// Same-cycle implication.
`define RRRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rrrq_pkg.sv */
// ----------------------------------------------------------------------------
// Run queue package
// Field widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package rrrq_pkg;

  localparam int MODE_W  = 3;
  localparam int TASK_W  = 5;
  localparam int SLICE_W = 16;
  localparam int CNT_W   = 6;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd100;

  localparam logic [MODE_W-1:0] MODE_ENQ_TAIL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_HEAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PICK     = 3'd4;

  typedef struct packed {
    logic accept;
    logic respond;
    logic res_pick;
    logic res_err;
    logic res_resched;
    logic cnt_inc;
    logic cnt_dec;
    logic slice_wr;
    logic unlink;
    logic link_tail;
    logic link_head;
    logic term_tail;
    logic term_head;
  } rrrq_cmd_t;

  typedef struct packed {
    logic is_enq;
    logic enq_head;
    logic is_deq;
    logic is_tick;
    logic is_pick;
    logic keep;
    logic linked;
    logic cnt_zero;
    logic expire;
    logic multi;
  } rrrq_sts_t;

endpackage

`default_nettype wire

/* rtl/round_robin_run_queue.sv */
// ----------------------------------------------------------------------------
// Round-robin run queue
// Doubly linked run queue of task slots with time slices and a runnable count.
// ----------------------------------------------------------------------------
// Usage: drive in_mode, in_task_id and in_keep_position with start high; the
// word is taken at a rising edge where busy is low. Each word yields exactly
// one result word, shown for one cycle with out_strobe high. The receiver
// cannot stall, so results must be taken when they appear.
// The slice reload value is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Pick, counted-only enqueue, re-link, dequeue and a tick that does not
// rotate are done in the execute state; an enqueue that links the task adds
// a terminate state; a tick that rotates an expired task to the tail unlinks
// it, links it at the tail and then terminates it. The next word is taken in
// the cycle its predecessor's result is shown. Each link memory has a single
// write port, which takes one pointer update per cycle.
// Reset empties the list, clears the count and linked flags and loads a
// slice reload of 100; the link and slice memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "round_robin_run_queue_macros.svh"

module round_robin_run_queue import rrrq_pkg::*; #(
  parameter int MAX_TASKS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [SLICE_W-1:0] cfg_wdata,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [TASK_W-1:0]  in_task_id,
  input  wire logic               in_keep_position,
  output logic                    out_strobe,
  output logic [TASK_W-1:0]       out_picked_task,
  output logic                    out_picked_valid,
  output logic                    out_resched_request,
  output logic                    out_link_error,
  output logic [CNT_W-1:0]        out_running_count
);

  localparam int COUNT_CAP = (MAX_TASKS < 63) ? MAX_TASKS : 63;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(COUNT_CAP);

  rrrq_cmd_t cmd;
  rrrq_sts_t sts;

  rrrq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  rrrq_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_mode             (in_mode),
    .in_task_id          (in_task_id),
    .in_keep_position    (in_keep_position),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_strobe          (out_strobe),
    .out_picked_task     (out_picked_task),
    .out_picked_valid    (out_picked_valid),
    .out_resched_request (out_resched_request),
    .out_link_error      (out_link_error),
    .out_running_count   (out_running_count)
  );

  `RRRQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `RRRQ_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result shown while still busy")
  `RRRQ_ASSERT_NOW(a_pick_count, out_strobe && out_picked_valid, out_running_count != '0, "valid pick with zero count")
  `RRRQ_ASSERT_NOW(a_count_cap, out_strobe, out_running_count <= CAP, "running count above its limit")

endmodule

`default_nettype wire

/* rtl/rrrq_ctrl.sv */
// ----------------------------------------------------------------------------
// Run queue controller
// Sequences each operation into memory read, unlink, link and terminate steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rrrq_ctrl import rrrq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  rrrq_sts_t      sts,
  output logic           busy,
  output rrrq_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_TERM_T,
    S_TERM_H
  } state_t;

  state_t state_r, state_nxt;
  logic   resched_r, resched_nxt;
  logic   busy_r;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    resched_nxt = resched_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept  = 1'b1;
          resched_nxt = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (sts.is_enq) begin
          cmd.cnt_inc = 1'b1;
          if (sts.keep) begin
            cmd.respond = 1'b1;
          end else if (sts.linked) begin
            cmd.respond = 1'b1;
            cmd.res_err = 1'b1;
          end else begin
            cmd.slice_wr = 1'b1;
            if (sts.enq_head) begin
              cmd.link_head = 1'b1;
              state_nxt     = S_TERM_H;
            end else begin
              cmd.link_tail = 1'b1;
              state_nxt     = S_TERM_T;
            end
          end
        end else if (sts.is_deq) begin
          cmd.respond = 1'b1;
          if (!sts.cnt_zero) begin
            cmd.cnt_dec = 1'b1;
            cmd.unlink  = sts.linked;
          end
        end else if (sts.is_tick) begin
          cmd.slice_wr = 1'b1;
          if (sts.expire && sts.linked && sts.multi) begin
            cmd.unlink  = 1'b1;
            resched_nxt = 1'b1;
            state_nxt   = S_LINK;
          end else begin
            cmd.respond = 1'b1;
          end
        end else begin
          cmd.respond  = 1'b1;
          cmd.res_pick = sts.is_pick;
        end
      end
      S_LINK: begin
        cmd.link_tail = 1'b1;
        state_nxt     = S_TERM_T;
      end
      S_TERM_T: begin
        cmd.term_tail   = 1'b1;
        cmd.respond     = 1'b1;
        cmd.res_resched = resched_r;
        state_nxt       = S_IDLE;
      end
      S_TERM_H: begin
        cmd.term_head = 1'b1;
        cmd.respond   = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      resched_r <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      resched_r <= resched_nxt;
      busy_r    <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

/* rtl/rrrq_dp.sv */
// ----------------------------------------------------------------------------
// Run queue datapath
// Link memories, slice memory, head and tail pointers, count and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rrrq_dp import rrrq_pkg::*; #(
  parameter int MAX_TASKS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [SLICE_W-1:0] cfg_wdata,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [TASK_W-1:0]  in_task_id,
  input  wire logic               in_keep_position,
  input  rrrq_cmd_t               cmd,
  output rrrq_sts_t               sts,
  output logic                    out_strobe,
  output logic [TASK_W-1:0]       out_picked_task,
  output logic                    out_picked_valid,
  output logic                    out_resched_request,
  output logic                    out_link_error,
  output logic [CNT_W-1:0]        out_running_count
);

  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int SLOT_W    = $clog2(MAX_TASKS + 1);
  localparam int EXT_W     = (SLOT_W > TASK_W) ? SLOT_W : TASK_W;
  localparam int COUNT_CAP = (MAX_TASKS < 63) ? MAX_TASKS : 63;
  localparam logic [SLOT_W-1:0] NIL = SLOT_W'(MAX_TASKS);
  localparam logic [CNT_W-1:0]  CAP = CNT_W'(COUNT_CAP);

  logic [SLOT_W-1:0]  next_mem [MAX_TASKS];
  logic [SLOT_W-1:0]  prev_mem [MAX_TASKS];
  logic [SLICE_W-1:0] slice_mem [MAX_TASKS];

  logic [MODE_W-1:0]    mode_r;
  logic [IDX_W-1:0]     tid_r;
  logic                 id_ok_r;
  logic                 keep_r;
  logic [SLOT_W-1:0]    head_r, head_nxt;
  logic [SLOT_W-1:0]    tail_r, tail_nxt;
  logic [MAX_TASKS-1:0] linked_r, linked_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SLICE_W-1:0]   reload_r;
  logic [SLOT_W-1:0]    rd_next_r, rd_prev_r;
  logic [SLICE_W-1:0]   rd_slice_r;
  logic                 out_strobe_r;
  logic [TASK_W-1:0]    out_task_r;
  logic                 out_valid_r, out_resched_r, out_err_r;
  logic [CNT_W-1:0]     out_count_r;

  logic [EXT_W-1:0]   id_ext;
  logic [IDX_W-1:0]   in_addr;
  logic               in_ok;
  logic [SLOT_W-1:0]  t_slot;
  logic [EXT_W-1:0]   head_ext;
  logic               pick_hit;
  logic               next_we, prev_we;
  logic [IDX_W-1:0]   next_waddr, prev_waddr;
  logic [SLOT_W-1:0]  next_wdata, prev_wdata;
  logic [SLICE_W-1:0] slice_wdata;

  assign id_ext   = EXT_W'(in_task_id);
  assign in_addr  = id_ext[IDX_W-1:0];
  assign in_ok    = (id_ext < EXT_W'(MAX_TASKS));
  assign t_slot   = SLOT_W'(tid_r);
  assign head_ext = EXT_W'(head_r);
  assign pick_hit = cmd.res_pick && (count_r != '0) && (head_r != NIL);

  always_comb begin
    sts = '0;
    unique case (mode_r) inside
      MODE_ENQ_TAIL, MODE_ENQ_HEAD: sts.is_enq = id_ok_r;
      MODE_DEQ:                     sts.is_deq = id_ok_r;
      MODE_TICK:                    sts.is_tick = id_ok_r;
      MODE_PICK:                    sts.is_pick = 1'b1;
      default:                      ;
    endcase
    sts.enq_head = (mode_r == MODE_ENQ_HEAD);
    sts.keep     = keep_r;
    sts.linked   = linked_r[tid_r];
    sts.cnt_zero = (count_r == '0);
    sts.expire   = (rd_slice_r == SLICE_W'(1));
    sts.multi    = (head_r != tail_r);
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = tid_r;
    next_wdata = NIL;
    prev_we    = 1'b0;
    prev_waddr = tid_r;
    prev_wdata = NIL;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    linked_nxt = linked_r;
    if (cmd.unlink) begin
      next_we    = (rd_prev_r != NIL);
      next_waddr = rd_prev_r[IDX_W-1:0];
      next_wdata = rd_next_r;
      prev_we    = (rd_next_r != NIL);
      prev_waddr = rd_next_r[IDX_W-1:0];
      prev_wdata = rd_prev_r;
      if (rd_prev_r == NIL) begin
        head_nxt = rd_next_r;
      end
      if (rd_next_r == NIL) begin
        tail_nxt = rd_prev_r;
      end
      linked_nxt[tid_r] = 1'b0;
    end
    if (cmd.link_tail) begin
      next_we    = (tail_r != NIL);
      next_waddr = tail_r[IDX_W-1:0];
      next_wdata = t_slot;
      prev_we    = 1'b1;
      prev_waddr = tid_r;
      prev_wdata = tail_r;
      if (tail_r == NIL) begin
        head_nxt = t_slot;
      end
      tail_nxt          = t_slot;
      linked_nxt[tid_r] = 1'b1;
    end
    if (cmd.link_head) begin
      next_we    = 1'b1;
      next_waddr = tid_r;
      next_wdata = head_r;
      prev_we    = (head_r != NIL);
      prev_waddr = head_r[IDX_W-1:0];
      prev_wdata = t_slot;
      if (head_r == NIL) begin
        tail_nxt = t_slot;
      end
      head_nxt          = t_slot;
      linked_nxt[tid_r] = 1'b1;
    end
    if (cmd.term_tail) begin
      next_we    = 1'b1;
      next_waddr = tid_r;
      next_wdata = NIL;
    end
    if (cmd.term_head) begin
      prev_we    = 1'b1;
      prev_waddr = tid_r;
      prev_wdata = NIL;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc && (count_r < CAP)) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign slice_wdata = (sts.is_tick && !sts.expire) ? (rd_slice_r - SLICE_W'(1)) : reload_r;

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (cmd.accept) begin
      rd_next_r <= next_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (cmd.accept) begin
      rd_prev_r <= prev_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slice_wr) begin
      slice_mem[tid_r] <= slice_wdata;
    end
    if (cmd.accept) begin
      rd_slice_r <= slice_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= NIL;
      tail_r       <= NIL;
      linked_r     <= '0;
      count_r      <= '0;
      reload_r     <= SLICE_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      linked_r     <= linked_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= cmd.respond;
      if (cfg_we) begin
        reload_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= in_mode;
      tid_r   <= in_addr;
      id_ok_r <= in_ok;
      keep_r  <= in_keep_position;
    end
    if (cmd.respond) begin
      out_task_r    <= pick_hit ? head_ext[TASK_W-1:0] : '0;
      out_valid_r   <= pick_hit;
      out_resched_r <= cmd.res_resched;
      out_err_r     <= cmd.res_err;
      out_count_r   <= count_nxt;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_picked_task     = out_task_r;
  assign out_picked_valid    = out_valid_r;
  assign out_resched_request = out_resched_r;
  assign out_link_error      = out_err_r;
  assign out_running_count   = out_count_r;

endmodule

`default_nettype wire

/* test/round_robin_run_queue_tb.sv */
// ----------------------------------------------------------------------------
// Round-robin run queue testbench
// Drives enqueue, dequeue, tick, pick and undefined-mode words into the run queue
// and checks every result word against a cycle-free model of the linked list, the
// time slices and the runnable count. Short directed sequences come first.
// Random phases follow, each under its own slice reload setting.
// ----------------------------------------------------------------------------
module round_robin_run_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrrq_pkg::*;

  localparam logic [5:0] NIL_SLOT    = 6'd32;
  localparam logic [5:0] COUNT_CAP   = 6'd32;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASES      = 8;
  localparam int         PHASE_WORDS = 225;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TASK_W-1:0] task_id;
    logic              keep;
  } op_t;

  typedef struct packed {
    logic [TASK_W-1:0] picked_task;
    logic              picked_valid;
    logic              resched_request;
    logic              link_error;
    logic [CNT_W-1:0]  running_count;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SLICE_W-1:0] cfg_wdata = '0;
  logic               start = 1'b0;
  logic [MODE_W-1:0]  in_mode = MODE_PICK;
  logic [TASK_W-1:0]  in_task_id = '0;
  logic               in_keep_position = 1'b0;
  logic               busy;
  logic               out_strobe;
  logic [TASK_W-1:0]  out_picked_task;
  logic               out_picked_valid;
  logic               out_resched_request;
  logic               out_link_error;
  logic [CNT_W-1:0]   out_running_count;

  round_robin_run_queue u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_task_id          (in_task_id),
    .in_keep_position    (in_keep_position),
    .out_strobe          (out_strobe),
    .out_picked_task     (out_picked_task),
    .out_picked_valid    (out_picked_valid),
    .out_resched_request (out_resched_request),
    .out_link_error      (out_link_error),
    .out_running_count   (out_running_count)
  );

  // Model state of the run queue.
  logic [5:0]         rq_next [32];
  logic [5:0]         rq_prev [32];
  logic [SLICE_W-1:0] rq_slice [32];
  logic [5:0]         rq_head = NIL_SLOT;
  logic [5:0]         rq_tail = NIL_SLOT;
  logic [31:0]        rq_linked = '0;
  logic [CNT_W-1:0]   rq_count = '0;
  logic [SLICE_W-1:0] rq_reload = SLICE_RESET;

  op_t      ops_waiting [$];
  outcome_t outcomes_due [$];
  logic [31:0] slice_known = '0;
  logic [4:0]  known_ids [$];

  op_t      taken;
  op_t      next_op;
  outcome_t due;
  outcome_t want;
  int       gap_pct = 22;
  int       stall_cycles = 0;
  int       fail_count = 0;
  int       words_sent = 0;
  int       results_seen = 0;
  int       rotations = 0;
  int       relinks = 0;
  int       valid_picks = 0;
  int       full_enqueues = 0;

  function automatic void link_tail(logic [4:0] t);
    rq_prev[t] = rq_tail;
    rq_next[t] = NIL_SLOT;
    if (rq_tail == NIL_SLOT) begin
      rq_head = {1'b0, t};
    end else begin
      rq_next[rq_tail[4:0]] = {1'b0, t};
    end
    rq_tail = {1'b0, t};
    rq_linked[t] = 1'b1;
  endfunction

  function automatic void unlink_slot(logic [4:0] t);
    logic [5:0] p;
    logic [5:0] n;
    p = rq_prev[t];
    n = rq_next[t];
    if (p == NIL_SLOT) begin
      rq_head = n;
    end else begin
      rq_next[p[4:0]] = n;
    end
    if (n == NIL_SLOT) begin
      rq_tail = p;
    end else begin
      rq_prev[n[4:0]] = p;
    end
    rq_linked[t] = 1'b0;
  endfunction

  function automatic outcome_t advance_run_queue(op_t op);
    outcome_t r;
    logic [SLICE_W-1:0] s;
    r = '0;
    case (op.mode)
      MODE_PICK: begin
        if (rq_count != 0 && rq_head != NIL_SLOT) begin
          r.picked_task  = rq_head[4:0];
          r.picked_valid = 1'b1;
        end
      end
      MODE_ENQ_TAIL, MODE_ENQ_HEAD: begin
        if (!op.keep) begin
          if (rq_linked[op.task_id]) begin
            r.link_error = 1'b1;
          end else begin
            if (op.mode == MODE_ENQ_HEAD) begin
              rq_next[op.task_id] = rq_head;
              rq_prev[op.task_id] = NIL_SLOT;
              if (rq_head == NIL_SLOT) begin
                rq_tail = {1'b0, op.task_id};
              end else begin
                rq_prev[rq_head[4:0]] = {1'b0, op.task_id};
              end
              rq_head = {1'b0, op.task_id};
              rq_linked[op.task_id] = 1'b1;
            end else begin
              link_tail(op.task_id);
            end
            rq_slice[op.task_id] = rq_reload;
          end
        end
        if (rq_count < COUNT_CAP) begin
          rq_count = rq_count + 1'b1;
        end
      end
      MODE_DEQ: begin
        if (rq_count != 0) begin
          if (rq_linked[op.task_id]) begin
            unlink_slot(op.task_id);
          end
          rq_count = rq_count - 1'b1;
        end
      end
      MODE_TICK: begin
        s = rq_slice[op.task_id] - 1'b1;
        if (s == 0) begin
          s = rq_reload;
          if (rq_linked[op.task_id] && rq_head != rq_tail) begin
            unlink_slot(op.task_id);
            link_tail(op.task_id);
            r.resched_request = 1'b1;
          end
        end
        rq_slice[op.task_id] = s;
      end
      default: begin
      end
    endcase
    r.running_count = rq_count;
    return r;
  endfunction

  // A slice is defined once the task has seen an enqueue that links it or
  // finds it linked; ticks are only aimed at such tasks.
  function automatic void push_op(logic [MODE_W-1:0] m, logic [TASK_W-1:0] t, logic k);
    op_t op;
    op.mode    = m;
    op.task_id = t;
    op.keep    = k;
    ops_waiting.push_back(op);
    if ((m == MODE_ENQ_TAIL || m == MODE_ENQ_HEAD) && !k && !slice_known[t]) begin
      slice_known[t] = 1'b1;
      known_ids.push_back(t);
    end
  endfunction

  function automatic void queue_random_ops(int count, int enq_w, int deq_w, int id_hi);
    int r;
    logic [TASK_W-1:0] t;
    logic [MODE_W-1:0] m;
    logic k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      t = TASK_W'($urandom_range(0, id_hi));
      k = ($urandom_range(0, 99) < 15);
      if (r < enq_w) begin
        m = ($urandom_range(0, 2) == 0) ? MODE_ENQ_HEAD : MODE_ENQ_TAIL;
      end else if (r < enq_w + deq_w) begin
        m = MODE_DEQ;
      end else if (r < enq_w + deq_w + 22 && known_ids.size() != 0) begin
        m = MODE_TICK;
        if (!slice_known[t]) begin
          t = known_ids[$urandom_range(0, known_ids.size() - 1)];
        end
      end else if (r < 98) begin
        m = MODE_PICK;
      end else begin
        m = MODE_PICK + 3'($urandom_range(1, 3));
      end
      push_op(m, t, k);
    end
  endfunction

  // Waits until no word is pending, in flight or owed a result, then
  // returns on a rising edge.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (ops_waiting.size() != 0 || outcomes_due.size() != 0 || start || busy);
    @(posedge clk);
  endtask

  task automatic write_slice_reload(logic [SLICE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    rq_reload = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken.mode    = in_mode;
        taken.task_id = in_task_id;
        taken.keep    = in_keep_position;
        due = advance_run_queue(taken);
        outcomes_due.push_back(due);
        words_sent++;
        rotations     += due.resched_request;
        relinks       += due.link_error;
        valid_picks   += due.picked_valid;
        if ((taken.mode == MODE_ENQ_TAIL || taken.mode == MODE_ENQ_HEAD) &&
            due.running_count == COUNT_CAP) begin
          full_enqueues++;
        end
      end
      if (!(start && busy)) begin
        if (ops_waiting.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          next_op = ops_waiting.pop_front();
          start            <= 1'b1;
          in_mode          <= next_op.mode;
          in_task_id       <= next_op.task_id;
          in_keep_position <= next_op.keep;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (outcomes_due.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        check_field("picked_task", 8'(want.picked_task), 8'(out_picked_task));
        check_field("picked_valid", 8'(want.picked_valid), 8'(out_picked_valid));
        check_field("resched_request", 8'(want.resched_request), 8'(out_resched_request));
        check_field("link_error", 8'(want.link_error), 8'(out_link_error));
        check_field("running_count", 8'(want.running_count), 8'(out_running_count));
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [SLICE_W-1:0] reloads [PHASES];
    int enq_w [PHASES];
    int deq_w [PHASES];
    int id_hi [PHASES];
    reloads = '{16'd3, 16'd1, 16'd65535, 16'd2, 16'd4, 16'd1, 16'd100, 16'd6};
    enq_w   = '{40, 45, 35, 30, 60, 25, 40, 35};
    deq_w   = '{30, 25, 30, 40, 15, 45, 30, 30};
    id_hi   = '{7, 3, 31, 7, 31, 3, 15, 7};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset slice value: empty queue, re-link, counted-only enqueue, a
    // dequeue of an unlinked task and a pick on an empty list with a count.
    push_op(MODE_PICK, 5'd0, 1'b0);
    push_op(MODE_DEQ, 5'd5, 1'b0);
    push_op(MODE_PICK + 3'd1, 5'd31, 1'b1);
    push_op(MODE_PICK + 3'd3, 5'd0, 1'b0);
    push_op(MODE_ENQ_TAIL, 5'd0, 1'b0);
    push_op(MODE_ENQ_TAIL, 5'd31, 1'b0);
    push_op(MODE_ENQ_HEAD, 5'd7, 1'b0);
    push_op(MODE_ENQ_TAIL, 5'd31, 1'b0);
    push_op(MODE_ENQ_HEAD, 5'd12, 1'b1);
    push_op(MODE_PICK, 5'd0, 1'b1);
    push_op(MODE_DEQ, 5'd20, 1'b0);
    push_op(MODE_TICK, 5'd0, 1'b0);
    push_op(MODE_DEQ, 5'd7, 1'b1);
    push_op(MODE_DEQ, 5'd0, 1'b0);
    push_op(MODE_DEQ, 5'd31, 1'b0);
    push_op(MODE_PICK, 5'd0, 1'b0);
    drain();

    // One-tick slices: rotation, the only linked task, an unlinked task.
    write_slice_reload(16'd1);
    push_op(MODE_ENQ_TAIL, 5'd3, 1'b0);
    push_op(MODE_ENQ_TAIL, 5'd4, 1'b0);
    push_op(MODE_TICK, 5'd3, 1'b0);
    push_op(MODE_PICK, 5'd0, 1'b0);
    push_op(MODE_DEQ, 5'd4, 1'b0);
    push_op(MODE_TICK, 5'd3, 1'b0);
    push_op(MODE_DEQ, 5'd3, 1'b0);
    push_op(MODE_TICK, 5'd3, 1'b0);
    drain();

    // A zero reload leaves a zero slice that wraps on the next tick.
    write_slice_reload(16'd0);
    push_op(MODE_ENQ_HEAD, 5'd8, 1'b0);
    push_op(MODE_TICK, 5'd8, 1'b0);
    push_op(MODE_PICK + 3'd2, 5'd21, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_slice_reload(reloads[p]);
      gap_pct = (p == 3) ? 0 : 22;
      queue_random_ops(PHASE_WORDS, enq_w[p], deq_w[p], id_hi[p]);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d command words and %0d result words over %0d reload settings.",
             words_sent, results_seen, PHASES + 3);
    $display("It saw %0d slice rotations, %0d re-link errors, %0d valid picks,",
             rotations, relinks, valid_picks);
    $display("and %0d full-count enqueues.", full_enqueues);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* round_robin_run_queue.f */
+incdir+rtl
rtl/rrrq_pkg.sv
rtl/rrrq_ctrl.sv
rtl/rrrq_dp.sv
rtl/round_robin_run_queue.sv
test/round_robin_run_queue_tb.sv
